// File: src/wbtm_pkg.sv
// ----------------------------------------------------------------------------
// wbtm_pkg: shared types and constants for the windowed busy-time meter
// Holds the transaction payload structs, the bucket slot record, the
// arithmetic unit operation codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wbtm_pkg;

  // Field widths
  localparam int TIME_BITS      = 48;
  localparam int SUM_BITS       = 32;
  localparam int REG_BITS       = 24;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  // Default number of coalescing buckets
  localparam int BUCKET_SLOTS_DEFAULT = 4;

  // Register reset values
  localparam logic [REG_BITS-1:0] WINDOW_RESET = REG_BITS'(100000);
  localparam logic [REG_BITS-1:0] BUCKET_RESET = REG_BITS'(50000);

  // Saturation limit of the bucket and result sums
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  // Input opcodes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_BUCKET_LENGTH = 2'd1
  } reg_index_t;

  typedef enum logic {
    ALU_SUB,
    ALU_SAT_ADD
  } alu_op_t;

  typedef struct packed {
    logic                 op;
    logic [TIME_BITS-1:0] timestamp;
    logic                 new_active;
  } in_item_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] elapsed_sum;
    logic [SUM_BITS-1:0] busy_sum;
  } out_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] stop_ts;
    logic [SUM_BITS-1:0]  elapsed;
    logic [SUM_BITS-1:0]  busy;
  } slot_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ELAP,
    S_CLAMP,
    S_START,
    S_AGE,
    S_TEST,
    S_MRG_EL,
    S_MRG_BUSY,
    S_OPEN,
    S_EV_RD,
    S_EV_AGE,
    S_EV_CMP,
    S_FINISH,
    S_SUM_RD,
    S_SUM_TOT,
    S_SUM_BUSY,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// File: src/windowed_busy_time_meter_core.sv
// ----------------------------------------------------------------------------
// windowed_busy_time_meter_core: sliding-window busy-time meter
// Input transactions (in_valid/in_stall) carry an opcode, a microsecond
// timestamp and a busy flag. An update stores the busy flag; a query returns
// the summed elapsed and busy time of the retained buckets as one output
// transaction (out_valid/out_stall). Updates return nothing.
// Config writes (cfg_valid/cfg_ready, always ready) set window_length
// (index 0) and bucket_length (index 1); unknown indexes are ignored.
// One transaction at a time runs through a sequencer that drives a single
// shared add/subtract unit and a bucket memory ring with one read and one
// write port. An update keeps in_stall high until it has charged the elapsed time
// to a new or merged bucket and evicted the buckets that end outside the window,
// so no new input is taken before then; a query also walks every retained bucket
// to sum it and then hands the result over. A finished query result sits in an
// output register, so a stalled receiver holds only that register: the next
// input transaction is taken while the result waits, and the sequencer
// waits at its end only if a second result is ready before the first leaves.
// Reset (rst, synchronous) clears last_check, the busy flag, the bucket
// count and the output valid, and restores the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module windowed_busy_time_meter_core
  import wbtm_pkg::*;
#(
  parameter int BUCKET_SLOTS = BUCKET_SLOTS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire in_item_t                  in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output out_item_t                      out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int PTR_BITS = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int CNT_BITS = $clog2(BUCKET_SLOTS + 1);
  localparam int WRAP_BITS = CNT_BITS + 1;
  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(BUCKET_SLOTS);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(BUCKET_SLOTS - 1);

  // Ring position base + off, folded back below BUCKET_SLOTS
  function automatic logic [PTR_BITS-1:0] wrap_ptr(input logic [PTR_BITS-1:0] base,
                                                   input logic [CNT_BITS-1:0] off);
    logic [WRAP_BITS-1:0] s;
    s = WRAP_BITS'(base) + WRAP_BITS'(off);
    if (s >= WRAP_BITS'(BUCKET_SLOTS)) begin
      s = s - WRAP_BITS'(BUCKET_SLOTS);
    end
    return s[PTR_BITS-1:0];
  endfunction

  // Configuration registers
  logic [REG_BITS-1:0] window_length;
  logic [REG_BITS-1:0] bucket_length;

  // Control state
  state_t              state;
  state_t              state_next;
  logic [PTR_BITS-1:0] head;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] idx;
  logic                busy_flag;
  logic [TIME_BITS-1:0] last_check;

  // Per-transaction datapath registers
  logic                 op_q;
  logic                 act_q;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] diff;
  logic [SUM_BITS-1:0]  elapsed;
  logic [SUM_BITS-1:0]  busy_amt;
  logic [SUM_BITS-1:0]  tot;
  logic [SUM_BITS-1:0]  bsy;

  // Shared unit and memory hookup
  alu_op_t              alu_op;
  logic [TIME_BITS-1:0] alu_a;
  logic [TIME_BITS-1:0] alu_b;
  logic [TIME_BITS-1:0] alu_res;
  logic                 alu_lt;
  logic                 mem_we;
  logic [PTR_BITS-1:0]  mem_waddr;
  slot_t                mem_wdata;
  logic                 mem_re;
  logic [PTR_BITS-1:0]  mem_raddr;
  slot_t                mem_rdata;

  logic in_fire;
  logic out_load;
  logic [TIME_BITS-1:0] window_ext;
  logic [TIME_BITS-1:0] bucket_ext;
  logic [PTR_BITS-1:0]  head_inc;

  assign in_fire    = in_valid & ~in_stall;
  assign in_stall   = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_load   = (state == S_OUT) & (~out_valid | ~out_stall);
  assign window_ext = TIME_BITS'(window_length);
  assign bucket_ext = TIME_BITS'(bucket_length);
  assign head_inc   = (head == LAST_PTR) ? '0 : head + PTR_BITS'(1);

  wbtm_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .lt  (alu_lt)
  );

  wbtm_slot_mem #(
    .DEPTH     (BUCKET_SLOTS),
    .ADDR_BITS (PTR_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
      bucket_length <= BUCKET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data[REG_BITS-1:0];
        REG_BUCKET_LENGTH: bucket_length <= cfg_data[REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, unit operands and memory accesses
  always_comb begin
    state_next = state;
    alu_op     = ALU_SUB;
    alu_a      = now_q;
    alu_b      = last_check;
    mem_we     = 1'b0;
    mem_waddr  = wrap_ptr(head, count - CNT_BITS'(1));
    mem_wdata  = '{stop_ts: now_q, elapsed: elapsed, busy: busy_amt};
    mem_re     = 1'b0;
    mem_raddr  = wrap_ptr(head, count - CNT_BITS'(1));
    unique case (state)
      S_IDLE: begin
        // Fetch the newest bucket while the transaction is taken
        mem_re = in_fire & (count != '0);
        if (in_fire) begin
          state_next = S_ELAP;
        end
      end
      S_ELAP: begin
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        alu_a = window_ext;
        alu_b = diff;
        state_next = (count == '0) ? S_OPEN : S_START;
      end
      S_START: begin
        alu_a = mem_rdata.stop_ts;
        alu_b = TIME_BITS'(mem_rdata.elapsed);
        state_next = S_AGE;
      end
      S_AGE: begin
        alu_a = now_q;
        alu_b = diff;
        state_next = S_TEST;
      end
      S_TEST: begin
        alu_a = diff;
        alu_b = bucket_ext;
        state_next = alu_lt ? S_MRG_EL : S_OPEN;
      end
      S_MRG_EL: begin
        alu_op = ALU_SAT_ADD;
        alu_a  = TIME_BITS'(mem_rdata.elapsed);
        alu_b  = TIME_BITS'(elapsed);
        state_next = S_MRG_BUSY;
      end
      S_MRG_BUSY: begin
        alu_op    = ALU_SAT_ADD;
        alu_a     = TIME_BITS'(mem_rdata.busy);
        alu_b     = TIME_BITS'(busy_amt);
        mem_we    = 1'b1;
        mem_wdata = '{stop_ts: now_q, elapsed: elapsed, busy: alu_res[SUM_BITS-1:0]};
        state_next = S_EV_RD;
      end
      S_OPEN: begin
        // A full ring overwrites its oldest slot
        mem_we    = 1'b1;
        mem_waddr = (count == FULL_COUNT) ? head : wrap_ptr(head, count);
        state_next = S_EV_RD;
      end
      S_EV_RD: begin
        mem_re    = 1'b1;
        mem_raddr = head;
        state_next = S_EV_AGE;
      end
      S_EV_AGE: begin
        alu_a = now_q;
        alu_b = mem_rdata.stop_ts;
        state_next = S_EV_CMP;
      end
      S_EV_CMP: begin
        alu_a = window_ext;
        alu_b = diff;
        if (alu_lt && count > CNT_BITS'(1)) begin
          state_next = S_EV_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = (op_q == OP_QUERY) ? S_SUM_RD : S_IDLE;
      end
      S_SUM_RD: begin
        mem_re    = 1'b1;
        mem_raddr = wrap_ptr(head, idx);
        state_next = S_SUM_TOT;
      end
      S_SUM_TOT: begin
        alu_op = ALU_SAT_ADD;
        alu_a  = TIME_BITS'(tot);
        alu_b  = TIME_BITS'(mem_rdata.elapsed);
        state_next = S_SUM_BUSY;
      end
      S_SUM_BUSY: begin
        alu_op = ALU_SAT_ADD;
        alu_a  = TIME_BITS'(bsy);
        alu_b  = TIME_BITS'(mem_rdata.busy);
        state_next = (idx + CNT_BITS'(1) == count) ? S_OUT : S_SUM_RD;
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers: ring pointer, fill count, flag and last timestamp
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      idx        <= '0;
      busy_flag  <= 1'b0;
      last_check <= '0;
    end else begin
      case (state)
        S_CLAMP: begin
          last_check <= now_q;
        end
        S_OPEN: begin
          if (count == FULL_COUNT) begin
            head <= head_inc;
          end else begin
            count <= count + CNT_BITS'(1);
          end
        end
        S_EV_CMP: begin
          // Drop the oldest bucket once its end falls outside the window, keeping at least one
          if (alu_lt && count > CNT_BITS'(1)) begin
            head  <= head_inc;
            count <= count - CNT_BITS'(1);
          end
        end
        S_FINISH: begin
          idx <= '0;
          if (op_q == OP_UPDATE) begin
            busy_flag <= act_q;
          end
        end
        S_SUM_BUSY: begin
          idx <= idx + CNT_BITS'(1);
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          op_q  <= in_data.op;
          act_q <= in_data.new_active;
          now_q <= in_data.timestamp;
        end
      end
      S_ELAP, S_START, S_AGE, S_EV_AGE: begin
        diff <= alu_res;
      end
      S_CLAMP: begin
        // Clamp the gap to the window length
        if (alu_lt) begin
          elapsed  <= SUM_BITS'(window_length);
          busy_amt <= busy_flag ? SUM_BITS'(window_length) : '0;
        end else begin
          elapsed  <= diff[SUM_BITS-1:0];
          busy_amt <= busy_flag ? diff[SUM_BITS-1:0] : '0;
        end
      end
      S_MRG_EL: begin
        elapsed <= alu_res[SUM_BITS-1:0];
      end
      S_FINISH: begin
        tot <= '0;
        bsy <= '0;
      end
      S_SUM_TOT: begin
        tot <= alu_res[SUM_BITS-1:0];
      end
      S_SUM_BUSY: begin
        bsy <= alu_res[SUM_BITS-1:0];
      end
      default: ;
    endcase
  end

  // Output register: load a finished result, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= '{elapsed_sum: tot, busy_sum: bsy};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("bucket count exceeds slot capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= LAST_PTR)
    else $error("ring head out of range");

  a_evict_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_EV_RD) |-> (count != '0))
    else $error("eviction walk on an empty ring");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT && $past(op_q) == OP_QUERY))
    else $error("result raised without a finished query");

  a_update_no_sum: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && op_q == OP_UPDATE) |=> (state == S_IDLE))
    else $error("update transaction entered the summing walk");
`endif

endmodule

`default_nettype wire

// File: src/wbtm_slot_mem.sv
// ----------------------------------------------------------------------------
// wbtm_slot_mem: bucket slot storage
// One write port and one read port with registered read data. The read
// data holds until the next read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wbtm_slot_mem
  import wbtm_pkg::*;
#(
  parameter int DEPTH     = BUCKET_SLOTS_DEFAULT,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire slot_t                wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output slot_t                     rdata
);

  slot_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/wbtm_alu.sv
// ----------------------------------------------------------------------------
// wbtm_alu: shared add/subtract unit
// Subtract gives the difference modulo 2^TIME_BITS and a less-than flag
// from the borrow; saturating add clamps the sum of two counts at SUM_MAX.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wbtm_alu
  import wbtm_pkg::*;
(
  input  wire alu_op_t              op,
  input  wire logic [TIME_BITS-1:0] a,
  input  wire logic [TIME_BITS-1:0] b,
  output logic [TIME_BITS-1:0]      res,
  output logic                      lt
);

  logic                 is_sub;
  logic [TIME_BITS-1:0] b_in;
  logic [TIME_BITS:0]   sum;
  logic                 sat;

  // One adder serves both operations
  always_comb begin
    is_sub = (op == ALU_SUB);
    b_in   = is_sub ? ~b : b;
    sum    = {1'b0, a} + {1'b0, b_in} + {{TIME_BITS{1'b0}}, is_sub};
    lt     = is_sub & ~sum[TIME_BITS];
    sat    = |sum[TIME_BITS:SUM_BITS];
    if (is_sub) begin
      res = sum[TIME_BITS-1:0];
    end else if (sat) begin
      res = {{(TIME_BITS-SUM_BITS){1'b0}}, SUM_MAX};
    end else begin
      res = sum[TIME_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: verif/busy_window_checker.sv
// ----------------------------------------------------------------------------
// busy_window_checker: prediction and comparison for the busy-time meter
// Watches the input, output and register write channels of the meter. It
// keeps its own copy of the bucket ring, the busy flag and both registers,
// works out the window totals that each query should return, and compares
// every output transaction with the oldest total still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module busy_window_checker
  import wbtm_pkg::*;
#(
  parameter int BUCKET_SLOTS = BUCKET_SLOTS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic                      in_stall,
  input  wire in_item_t                  in_data,
  input  wire logic                      out_valid,
  input  wire logic                      out_stall,
  input  wire out_item_t                 out_data,
  input  wire logic                      cfg_valid,
  input  wire logic                      cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                      closing,
  output int                             outstanding,
  output int                             fail_count
);

  // Predicted meter state
  logic [REG_BITS-1:0]  window_len;
  logic [REG_BITS-1:0]  bucket_len;
  logic [TIME_BITS-1:0] last_seen;
  logic                 busy_now;
  logic [TIME_BITS-1:0] bkt_end     [BUCKET_SLOTS];
  logic [SUM_BITS-1:0]  bkt_elapsed [BUCKET_SLOTS];
  logic [SUM_BITS-1:0]  bkt_busy    [BUCKET_SLOTS];
  int                   bkt_count;

  // Window totals owed by queries already accepted
  out_item_t totals_due[$];
  int        mismatches = 0;
  bit        closed = 1'b0;

  assign fail_count = mismatches;

  function automatic logic [SUM_BITS-1:0] sat_sum(input logic [SUM_BITS-1:0] a,
                                                  input logic [SUM_BITS-1:0] b);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
  endfunction

  // Drop the oldest bucket and shift the rest down
  task automatic retire_oldest_bucket();
    for (int i = 1; i < bkt_count; i++) begin
      bkt_end[i-1]     = bkt_end[i];
      bkt_elapsed[i-1] = bkt_elapsed[i];
      bkt_busy[i-1]    = bkt_busy[i];
    end
    bkt_count--;
  endtask

  // Charge the time since the last transaction to the buckets
  task automatic credit_interval(input logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] gap;
    logic [TIME_BITS-1:0] bstart;
    logic [SUM_BITS-1:0]  span;
    logic [SUM_BITS-1:0]  span_busy;
    bit                   merged;
    int                   n;
    gap = now - last_seen;
    if (gap > TIME_BITS'(window_len)) gap = TIME_BITS'(window_len);
    span = gap[SUM_BITS-1:0];
    span_busy = busy_now ? span : '0;
    merged = 1'b0;
    // merge into the newest bucket while it is younger than one bucket span
    if (bkt_count > 0) begin
      n = bkt_count - 1;
      bstart = bkt_end[n] - TIME_BITS'(bkt_elapsed[n]);
      if (TIME_BITS'(now - bstart) < TIME_BITS'(bucket_len)) begin
        merged = 1'b1;
        bkt_end[n]     = now;
        bkt_elapsed[n] = sat_sum(bkt_elapsed[n], span);
        bkt_busy[n]    = sat_sum(bkt_busy[n], span_busy);
      end
    end
    // open a new bucket, dropping the oldest if the ring is full
    if (!merged) begin
      if (bkt_count >= BUCKET_SLOTS) retire_oldest_bucket();
      bkt_end[bkt_count]     = now;
      bkt_elapsed[bkt_count] = span;
      bkt_busy[bkt_count]    = span_busy;
      bkt_count++;
    end
    // evict buckets that ended before the window
    while (bkt_count > 0 && TIME_BITS'(now - bkt_end[0]) > TIME_BITS'(window_len))
      retire_oldest_bucket();
    last_seen = now;
  endtask

  task automatic apply_request(input in_item_t req);
    out_item_t sums;
    credit_interval(req.timestamp);
    if (req.op == OP_UPDATE) begin
      busy_now = req.new_active;
    end else begin
      sums = '0;
      for (int i = 0; i < bkt_count; i++) begin
        sums.elapsed_sum = sat_sum(sums.elapsed_sum, bkt_elapsed[i]);
        sums.busy_sum    = sat_sum(sums.busy_sum, bkt_busy[i]);
      end
      totals_due.insert(totals_due.size(), sums);
    end
  endtask

  task automatic check_totals(input out_item_t got);
    out_item_t want;
    if (totals_due.size() == 0) begin
      $display("%0t: expected no result, got elapsed %0d busy %0d",
               $time, got.elapsed_sum, got.busy_sum);
      mismatches++;
    end else begin
      want = totals_due[0];
      totals_due.delete(0);
      if (got.elapsed_sum !== want.elapsed_sum) begin
        $display("%0t: elapsed_sum expected %0d got %0d",
                 $time, want.elapsed_sum, got.elapsed_sum);
        mismatches++;
      end
      if (got.busy_sum !== want.busy_sum) begin
        $display("%0t: busy_sum expected %0d got %0d",
                 $time, want.busy_sum, got.busy_sum);
        mismatches++;
      end
    end
  endtask

  // Follow every transaction on the three channels
  always @(posedge clk) begin
    if (rst) begin
      window_len = WINDOW_RESET;
      bucket_len = BUCKET_RESET;
      last_seen  = '0;
      busy_now   = 1'b0;
      bkt_count  = 0;
      totals_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW_LENGTH) window_len = cfg_data[REG_BITS-1:0];
        else if (cfg_index == REG_BUCKET_LENGTH) bucket_len = cfg_data[REG_BITS-1:0];
      end
      if (in_valid && !in_stall) apply_request(in_data);
      if (out_valid && !out_stall) check_totals(out_data);
      // flag totals that never arrived
      if (closing && !closed) begin
        closed = 1'b1;
        if (totals_due.size() != 0) begin
          $display("%0t: query results expected %0d more, got 0",
                   $time, totals_due.size());
          mismatches++;
        end
      end
    end
    outstanding <= totals_due.size();
  end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the windowed busy-time meter core
// Drives update and query transactions with random gaps and output stalls,
// reprograms the window and bucket lengths between phases, and leaves all
// checking to busy_window_checker. A directed opening covers the edges of
// the timestamp, time going backwards, zero registers and a full ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import wbtm_pkg::*;

  localparam int LIMIT_CYCLES    = 1000000;
  localparam int SETTLE_CYCLES   = 64;
  localparam int RANDOM_ITEMS    = 1850;
  localparam int PHASES          = 8;
  localparam int RANDOM_PHASE    = 4;
  localparam int PRESSURE_AFTER  = 300;
  localparam int PRESSURE_CYCLES = 400;

  // Register indexes the meter does not implement
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  in_item_t                  in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_item_t                 out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      closing = 1'b0;
  int                        outstanding;
  int                        fail_count;

  // Stimulus state
  logic [TIME_BITS-1:0] stamp = '0;
  logic [REG_BITS-1:0]  win_cfg = WINDOW_RESET;
  logic [REG_BITS-1:0]  bkt_cfg = BUCKET_RESET;
  int                   gap_pct = 20;
  int                   sent_count = 0;
  int                   cycle_count = 0;
  bit                   quiet = 1'b0;
  bit                   pressure_done = 1'b0;

  windowed_busy_time_meter_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  busy_window_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .closing    (closing),
    .outstanding(outstanding),
    .fail_count (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Next timestamp: mostly small forward steps, some long gaps, some chaos
  function automatic logic [TIME_BITS-1:0] pick_timestamp(input logic [TIME_BITS-1:0] prev);
    logic [63:0] rnd;
    int          sel;
    rnd = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sel < 45) return prev + TIME_BITS'($urandom_range(0, bkt_cfg / 2 + 1));
    if (sel < 70) return prev + TIME_BITS'($urandom_range(0, win_cfg));
    if (sel < 82) return prev + TIME_BITS'(win_cfg) + TIME_BITS'($urandom_range(0, win_cfg));
    if (sel < 88) return prev;
    if (sel < 93) return prev - TIME_BITS'($urandom_range(1, 1000));
    if (sel < 97) return rnd[TIME_BITS-1:0];
    return prev + rnd[TIME_BITS-1:0];
  endfunction

  // Offer one transaction, after an optional idle burst, until it is taken
  task automatic send(input logic op, input logic [TIME_BITS-1:0] ts, input logic act);
    in_item_t item;
    item.op         = op;
    item.timestamp  = ts;
    item.new_active = act;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    stamp = ts;
    sent_count++;
  endtask

  task automatic send_random();
    logic op;
    op = ($urandom_range(0, 99) < 35) ? OP_QUERY : OP_UPDATE;
    send(op, pick_timestamp(stamp), 1'($urandom));
  endtask

  // Hold one register write until it is taken; junk in the unused upper bits
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [REG_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= {8'($urandom), val};
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [REG_BITS-1:0] win,
                              input logic [REG_BITS-1:0] bkt);
    write_reg(REG_WINDOW_LENGTH, win);
    write_reg(REG_BUCKET_LENGTH, bkt);
    cfg_valid <= 1'b0;
    win_cfg = win;
    bkt_cfg = bkt;
  endtask

  // Drop valid, wait for every result, then let trailing updates drain
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stall bursts, one long hold-off, none near the end
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!pressure_done && sent_count >= PRESSURE_AFTER) begin
        out_stall <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // Cycle limit
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [REG_BITS-1:0] win;
    logic [REG_BITS-1:0] bkt;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset register values
    send(OP_QUERY,  48'd0,      1'b1);
    send(OP_UPDATE, 48'd10,     1'b1);
    send(OP_QUERY,  48'd30010,  1'b0);
    send(OP_UPDATE, 48'd60000,  1'b0);
    send(OP_QUERY,  48'd60000,  1'b1);
    send(OP_UPDATE, 48'd200000, 1'b1);
    send(OP_QUERY,  48'd200500, 1'b0);
    send(OP_QUERY,  48'd260600, 1'b0);
    send(OP_QUERY,  48'd320700, 1'b0);
    send(OP_QUERY,  48'd380800, 1'b0);
    // time going backwards
    send(OP_QUERY,  48'd100,    1'b0);
    // top of the timestamp range, then wrap forward
    send(OP_UPDATE, {TIME_BITS{1'b1}}, 1'b1);
    send(OP_QUERY,  48'd3,      1'b0);
    send(OP_UPDATE, 48'd3,      1'b0);
    send(OP_QUERY,  48'd50003,  1'b1);
    finish_phase();

    // Directed: unknown indexes are ignored, then both registers at zero
    write_reg(REG_SPARE_LO, 24'h00_0005);
    write_reg(REG_SPARE_HI, 24'hFF_FFFF);
    program_regs('0, '0);
    send(OP_UPDATE, stamp + 48'd500, 1'b1);
    send(OP_QUERY,  stamp,           1'b0);
    send(OP_QUERY,  stamp + 48'd10,  1'b0);
    send(OP_UPDATE, stamp,           1'b0);
    send(OP_QUERY,  stamp + 48'd20,  1'b1);
    finish_phase();

    // Directed: wide window, short buckets, so the ring overflows
    program_regs({REG_BITS{1'b1}}, 24'd1000);
    for (int k = 0; k < 6; k++) send(OP_QUERY, stamp + 48'd2000, 1'(k));
    finish_phase();

    // Random phases over a spread of register settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin win = WINDOW_RESET;      bkt = BUCKET_RESET;      end
        1: begin win = 24'd1000;          bkt = 24'd300;           end
        2: begin win = {REG_BITS{1'b1}};  bkt = {REG_BITS{1'b1}};  end
        3: begin win = 24'd1;             bkt = 24'd1;             end
        RANDOM_PHASE: begin
          win = REG_BITS'($urandom_range(1, 24'hFF_FFFF));
          bkt = REG_BITS'($urandom_range(1, 24'hFF_FFFF));
        end
        5: begin win = {REG_BITS{1'b1}};  bkt = 24'd1;             end
        6: begin win = 24'd1;             bkt = {REG_BITS{1'b1}};  end
        default: begin win = 24'd5000;    bkt = 24'd20000;         end
      endcase
      program_regs(win, bkt);
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 30;
      endcase
      quiet = (p == PHASES - 1);
      repeat (RANDOM_ITEMS / PHASES) send_random();
      finish_phase();
    end

    closing <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
